/* sv/oal_pkg.sv */
// Package for the ordered array list: sizes, opcode/status/state codes and
// the structs passed between the sequencer, the RAM wrapper and the top level.
// No dependencies.
package oal_pkg;

  // Storage geometry
  localparam int LIST_DEPTH = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Fixed port field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 3;
  localparam int FIDX_W = 6;
  localparam int ICNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT  = 3'd0,
    OP_ERASE_AT   = 3'd1,
    OP_SEARCH     = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_PUSH_FRONT = 3'd5,
    OP_POP_FRONT  = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_PUT,
    S_SRD,
    S_SCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   found;
    logic [CNT_W-1:0]    count;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
  } ram_wr_t;

endpackage

/* sv/ordered_array_list.sv */
// Ordered array list: a fixed-capacity contiguous list held in one RAM.
//
// Input channel (in_valid / in_stall): one request per handshake, carrying
// opcode, position and value. Output channel (out_valid / out_stall): one
// result per request with status, found_index and item_count.
// A request is taken only while the sequencer is idle; it then walks the
// element RAM one entry at a time, a read step and then a write or compare
// step per entry, limited by the single read port with registered data.
// The sequencer goes back to idle after its done step, and only then is
// the next request taken; requests are never overlapped.
// The output register holds a finished result while out_stall is high; the
// sequencer waits in its done step and takes no new request until then.
// Reset empties the list (count zero); stored data is not cleared.
// Depends on oal_pkg, oal_ctrl and oal_ram.
module ordered_array_list
  import oal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [VAL_W-1:0]  value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STS_W-1:0]         status,
  output logic [FIDX_W-1:0]        found_index,
  output logic [ICNT_W-1:0]        item_count
);

  logic                  busy;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  ram_wr_t               wr;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;

  assign in_stall  = busy;
  assign res_ready = !out_valid || !out_stall;

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_op    (op_t'(opcode)),
    .req_pos   (CNT_W'(position)),
    .req_val   (DATA_WIDTH'(unsigned'(value))),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  oal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: valid flag reset, payload loaded with each result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      status      <= STS_W'(res.status);
      found_index <= FIDX_W'(res.found);
      item_count  <= ICNT_W'(res.count);
    end
  end

endmodule

/* sv/oal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/oal_ctrl.sv */
// Sequencer of the ordered array list: decodes a request, walks the element
// RAM one entry at a time (shift up, shift down, search) and forms the result.
// Depends on oal_pkg.
module oal_ctrl
  import oal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  op_t                   req_op,
  input  logic [CNT_W-1:0]      req_pos,
  input  logic [DATA_WIDTH-1:0] req_val,
  output logic                  busy,
  output logic [ADDR_W-1:0]     rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data,
  output ram_wr_t               wr,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  state_t                state, state_next;
  op_t                   op, op_next;
  logic [CNT_W-1:0]      pos, pos_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      count, count_next;
  status_t               status, status_next;
  logic [ADDR_W-1:0]     found, found_next;
  logic                  shrink, shrink_next;

  logic [CNT_W-1:0]      eff_pos;
  logic [CNT_W-1:0]      src;
  logic [CNT_W-1:0]      count_m1;
  logic                  req_acc;

  assign busy      = (state != S_IDLE);
  assign req_acc   = req_valid && (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: status, found: found, count: count};

  // Shared index step: neighbor entry in the walk direction
  assign src      = shrink ? (idx + CNT_W'(1)) : (idx - CNT_W'(1));
  assign count_m1 = count - CNT_W'(1);

  // Effective position of the request
  always_comb begin
    unique case (req_op)
      OP_INSERT_AT, OP_ERASE_AT:  eff_pos = req_pos;
      OP_PUSH_BACK:               eff_pos = count;
      OP_POP_BACK:                eff_pos = count_m1;
      default:                    eff_pos = '0;
    endcase
  end

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op     <= op_next;
    pos    <= pos_next;
    val    <= val_next;
    idx    <= idx_next;
    status <= status_next;
    found  <= found_next;
    shrink <= shrink_next;
  end

  // Next state, RAM control and result bookkeeping
  always_comb begin
    state_next  = state;
    op_next     = op;
    pos_next    = pos;
    val_next    = val;
    idx_next    = idx;
    count_next  = count;
    status_next = status;
    found_next  = found;
    shrink_next = shrink;
    rd_addr     = idx[ADDR_W-1:0];
    wr          = '{en: 1'b0, addr: idx[ADDR_W-1:0], data: rd_data};

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next     = req_op;
          val_next    = req_val;
          pos_next    = eff_pos;
          status_next = STS_OK;
          found_next  = '0;
          state_next  = S_DONE;
          unique case (req_op)
            OP_INSERT_AT, OP_PUSH_BACK, OP_PUSH_FRONT: begin
              shrink_next = 1'b0;
              idx_next    = count;
              if (eff_pos > count) begin
                status_next = STS_BADPOS;
              end else if (count >= CNT_W'(LIST_DEPTH)) begin
                status_next = STS_FULL;
              end else if (count > eff_pos) begin
                state_next = S_RD;
              end else begin
                state_next = S_PUT;
              end
            end
            OP_ERASE_AT, OP_POP_BACK, OP_POP_FRONT: begin
              shrink_next = 1'b1;
              idx_next    = eff_pos;
              if (count == '0) begin
                status_next = STS_EMPTY;
              end else if (eff_pos >= count) begin
                status_next = STS_BADPOS;
              end else if (eff_pos < count_m1) begin
                state_next = S_RD;
              end else begin
                count_next = count_m1;
              end
            end
            OP_SEARCH: begin
              idx_next    = '0;
              status_next = STS_NOTFOUND;
              if (count != '0) begin
                state_next = S_SRD;
              end
            end
            OP_NOP: begin
              status_next = STS_OK;
            end
          endcase
        end
      end

      // Fetch the neighbor entry
      S_RD: begin
        rd_addr    = src[ADDR_W-1:0];
        state_next = S_WR;
      end

      // Move it into the current slot, then step
      S_WR: begin
        wr       = '{en: 1'b1, addr: idx[ADDR_W-1:0], data: rd_data};
        idx_next = src;
        if (shrink) begin
          if (src < count_m1) begin
            state_next = S_RD;
          end else begin
            count_next = count_m1;
            state_next = S_DONE;
          end
        end else if (src > pos) begin
          state_next = S_RD;
        end else begin
          state_next = S_PUT;
        end
      end

      // Drop the new element into its slot
      S_PUT: begin
        wr         = '{en: 1'b1, addr: pos[ADDR_W-1:0], data: val};
        count_next = count + CNT_W'(1);
        state_next = S_DONE;
      end

      S_SRD: begin
        state_next = S_SCMP;
      end

      // Compare one stored element against the key
      S_SCMP: begin
        if (rd_data == val) begin
          status_next = STS_OK;
          found_next  = idx[ADDR_W-1:0];
          state_next  = S_DONE;
        end else if (idx < count_m1) begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_SRD;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("element count above capacity");

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_WR || state == S_PUT))
    else $error("RAM write outside a shift or put step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state != S_IDLE))
    else $error("accepted request did not start");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE || (state == S_IDLE && !req_valid)) |=> $stable(count))
    else $error("count changed while no request is in work");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && op == OP_SEARCH && status == STS_OK) |-> (CNT_W'(found) < count))
    else $error("search hit beyond the element count");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for ordered_array_list: a directed table of list requests, then
// random insert/erase/search traffic, each reply checked against a typed reply or a shadow list model.
// Depends on oal_pkg and the ordered_array_list RTL.
module tb_top
  import oal_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 200;

  // one request of the directed table; a fixed reply is typed in where obvious
  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic              fixed;
    status_t           status;
    logic [FIDX_W-1:0] found_index;
    logic [ICNT_W-1:0] item_count;
  } list_row_t;

  typedef struct packed {
    status_t           status;
    logic [FIDX_W-1:0] found_index;
    logic [ICNT_W-1:0] item_count;
  } list_reply_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    opcode;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   value;
  logic               out_valid;
  logic               out_stall;
  logic [STS_W-1:0]   status;
  logic [FIDX_W-1:0]  found_index;
  logic [ICNT_W-1:0]  item_count;

  // shadow copy of the list contents
  logic [DATA_WIDTH-1:0] shadow_list [LIST_DEPTH];
  int                    shadow_count = 0;

  list_reply_t replies_due [$];
  list_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          send_gap_pct = 28;
  int          stall_pct = 63;
  logic        pressure_go = 1'b0;

  ordered_array_list dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .item_count  (item_count)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow list and return the reply it must produce.
  function automatic list_reply_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                                logic [VAL_W-1:0] val);
    list_reply_t r;
    int          slot;
    int          i;
    r.status = STS_OK;
    r.found_index = '0;
    case (op)
      OP_INSERT_AT, OP_PUSH_BACK, OP_PUSH_FRONT: begin
        slot = (op == OP_INSERT_AT) ? int'(pos) :
               (op == OP_PUSH_BACK) ? shadow_count : 0;
        // position check wins over the full check
        if (slot > shadow_count) begin
          r.status = STS_BADPOS;
        end else if (shadow_count >= LIST_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          for (i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = val[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      OP_ERASE_AT, OP_POP_BACK, OP_POP_FRONT: begin
        slot = (op == OP_ERASE_AT) ? int'(pos) :
               (op == OP_POP_BACK) ? shadow_count - 1 : 0;
        // empty check wins over the position check
        if (shadow_count == 0) begin
          r.status = STS_EMPTY;
        end else if (slot >= shadow_count) begin
          r.status = STS_BADPOS;
        end else begin
          for (i = slot; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        r.status = STS_NOTFOUND;
        for (i = 0; i < shadow_count && r.status != STS_OK; i++) begin
          if (shadow_list[i] == val[DATA_WIDTH-1:0]) begin
            r.status = STS_OK;
            r.found_index = i[FIDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.item_count = shadow_count[ICNT_W-1:0];
    return r;
  endfunction

  // Offer one request, wait for it to be taken, then queue its reply.
  task automatic send_request(list_row_t row);
    list_reply_t predicted;
    list_reply_t typed;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= row.op;
    position <= row.pos;
    value    <= row.val;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_list_op(row.op, row.pos, row.val);
    typed = '{status: row.status, found_index: row.found_index, item_count: row.item_count};
    replies_due.push_back(row.fixed ? typed : predicted);
  endtask

  task automatic add_row(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                         logic fixed, status_t sts, int fidx, int cnt);
    directed_rows.push_back('{op: op, pos: pos, val: val, fixed: fixed, status: sts,
                              found_index: fidx[FIDX_W-1:0], item_count: cnt[ICNT_W-1:0]});
  endtask

  // Stimulus: directed table, then random traffic in three idling phases
  initial begin
    list_row_t row;
    int        drift;
    int        seg_left;
    int        roll;
    bit        grow;
    int        kind;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    opcode   <= OP_NOP;
    position <= '0;
    value    <= '0;
    drift = 0;
    seg_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty list errors, then build and probe a short list
    add_row(OP_POP_BACK,   7'd0,   32'h0,         1, STS_EMPTY,    0, 0);
    add_row(OP_POP_FRONT,  7'd0,   32'h0,         1, STS_EMPTY,    0, 0);
    add_row(OP_ERASE_AT,   7'd0,   32'h0,         1, STS_EMPTY,    0, 0);
    add_row(OP_ERASE_AT,   7'd127, 32'h0,         1, STS_EMPTY,    0, 0);
    add_row(OP_SEARCH,     7'd0,   32'h0,         1, STS_NOTFOUND, 0, 0);
    add_row(OP_INSERT_AT,  7'd1,   32'h1,         1, STS_BADPOS,   0, 0);
    add_row(OP_INSERT_AT,  7'd0,   32'h7FFF_FFFF, 1, STS_OK,       0, 1);
    add_row(OP_PUSH_BACK,  7'd127, 32'h8000_0000, 1, STS_OK,       0, 2);
    add_row(OP_PUSH_FRONT, 7'd127, 32'h0,         1, STS_OK,       0, 3);
    add_row(OP_PUSH_BACK,  7'd0,   32'hFFFF_FFFF, 1, STS_OK,       0, 4);
    add_row(OP_INSERT_AT,  7'd4,   32'h5555_5555, 0, STS_OK,       0, 0);
    add_row(OP_INSERT_AT,  7'd2,   32'hAAAA_AAAA, 0, STS_OK,       0, 0);
    add_row(OP_SEARCH,     7'd0,   32'h8000_0000, 0, STS_OK,       0, 0);
    add_row(OP_SEARCH,     7'd0,   32'h1234_5678, 0, STS_OK,       0, 0);
    add_row(OP_ERASE_AT,   7'd6,   32'h0,         1, STS_BADPOS,   0, 6);
    add_row(OP_ERASE_AT,   7'd127, 32'h0,         1, STS_BADPOS,   0, 6);
    add_row(OP_INSERT_AT,  7'd127, 32'h0,         1, STS_BADPOS,   0, 6);
    add_row(OP_ERASE_AT,   7'd2,   32'h0,         0, STS_OK,       0, 0);
    add_row(OP_POP_FRONT,  7'd0,   32'h0,         0, STS_OK,       0, 0);
    add_row(OP_POP_BACK,   7'd0,   32'h0,         0, STS_OK,       0, 0);
    add_row(OP_NOP,        7'd127, 32'hFFFF_FFFF, 1, STS_OK,       0, 3);
    add_row(OP_PUSH_BACK,  7'd0,   32'h7FFF_FFFF, 0, STS_OK,       0, 0);
    add_row(OP_SEARCH,     7'd0,   32'h7FFF_FFFF, 0, STS_OK,       0, 0);
    add_row(OP_SEARCH,     7'd0,   32'hFFFF_FFFF, 0, STS_OK,       0, 0);
    add_row(OP_INSERT_AT,  7'd64,  32'h0,         1, STS_BADPOS,   0, 4);
    foreach (directed_rows[k]) send_request(directed_rows[k]);

    // random part: segments that drift toward full, toward empty, or stay mixed
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3) begin
        send_gap_pct = 63;
        stall_pct = 28;
      end
      if (n == 2 * RANDOM_REQUESTS / 3) begin
        send_gap_pct = 0;
        stall_pct = 0;
        pressure_go <= 1'b1;
      end
      if (seg_left == 0) begin
        drift = $urandom_range(0, 2);
        seg_left = $urandom_range(40, 160);
      end
      seg_left--;

      row = '0;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        row.op = OP_NOP;
      end else if (roll < 18) begin
        row.op = OP_SEARCH;
      end else begin
        grow = (drift == 0) ? ($urandom_range(0, 99) < 80) :
               (drift == 1) ? ($urandom_range(0, 99) < 20) : ($urandom_range(0, 1) == 1);
        kind = $urandom_range(0, 2);
        if (grow) row.op = (kind == 0) ? OP_INSERT_AT : (kind == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else      row.op = (kind == 0) ? OP_ERASE_AT : (kind == 1) ? OP_POP_BACK : OP_POP_FRONT;
      end

      // mostly legal positions, sometimes anything the field holds
      if ($urandom_range(0, 9) == 0 || (row.op != OP_INSERT_AT && row.op != OP_ERASE_AT))
        row.pos = POS_W'($urandom_range(0, 127));
      else if (row.op == OP_INSERT_AT)
        row.pos = POS_W'($urandom_range(0, shadow_count));
      else
        row.pos = (shadow_count > 0) ? POS_W'($urandom_range(0, shadow_count - 1)) : '0;

      // values: existing elements for searches, small and extreme values, full random
      roll = $urandom_range(0, 99);
      if (row.op == OP_SEARCH && shadow_count > 0 && roll < 60) begin
        row.val = shadow_list[$urandom_range(0, shadow_count - 1)];
      end else if (roll < 75) begin
        row.val = $urandom;
      end else if (roll < 95) begin
        row.val = $urandom_range(0, 15);
        if (row.val[3]) row.val = row.val | 32'hFFFF_FFF0;
      end else begin
        row.val = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      send_request(row);
    end
    in_valid <= 1'b0;

    // drain, then allow the latency of one more request
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
    if (mismatch_count == 0) begin
      $display("PASS ordered_array_list");
    end else begin
      $display("FAIL ordered_array_list");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the list backs up
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Reply checker: compare each accepted reply with the oldest one due
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status=%0d index=%0d count=%0d",
                                  status, found_index, item_count));
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (found_index !== want.found_index)
          report_mismatch($sformatf("found_index got %0d want %0d",
                                    found_index, want.found_index));
        if (item_count !== want.item_count)
          report_mismatch($sformatf("item_count got %0d want %0d",
                                    item_count, want.item_count));
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAIL ordered_array_list");
    $finish;
  end

endmodule
